### rtl/core/ps2mpc_pkg.sv
package ps2mpc_pkg;

    localparam int DATA_W       = 8;
    localparam int SIZE_W       = 13;
    localparam int STATUS_W     = 2;
    localparam int BUTTON_W     = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int PACKET_BYTES = 3;
    localparam int POS_W        = $clog2(PACKET_BYTES);

    localparam int SYNC_BIT   = 3;
    localparam int SIGN_X_BIT = 4;
    localparam int SIGN_Y_BIT = 5;

    localparam logic [SIZE_W-1:0] DEFAULT_WIDTH  = 13'd1024;
    localparam logic [SIZE_W-1:0] DEFAULT_HEIGHT = 13'd768;

    typedef enum logic [STATUS_W-1:0] {
        STAT_STORED  = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_DONE    = 2'd2
    } status_t;

    typedef enum logic [POS_W-1:0] {
        POS_FLAGS = 2'd0,
        POS_DX    = 2'd1,
        POS_DY    = 2'd2
    } pos_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } reg_index_t;

endpackage

### rtl/core/ps2_mouse_packet_cursor.sv
// Channel   Direction  Word contents (lowest bits first)
// s_        in         tdata: data_byte[7:0]
// m_        out        tdata: cursor_x, cursor_y, button_bits, zero pad; tuser: byte_status
// cfg_      in         cfg_index selects the register, cfg_data carries the size
//
// Each byte passes two registers on its way to a result: the input register, and then
// the result register, loaded as the byte is decoded and the cursor updated.
// A new byte is accepted every cycle while results are taken.
// While a result waits in the output register, the input register takes one more byte
// and then the input stalls until the result is taken.
// Reset is synchronous and active low; it restores the default sizes and centers the cursor.
module ps2_mouse_packet_cursor #(
    parameter int COORD_BITS = 12,
    localparam int M_TDATA_W = ((2 * COORD_BITS + ps2mpc_pkg::BUTTON_W + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ps2mpc_pkg::DATA_W-1:0]       s_tdata,    // data_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [M_TDATA_W-1:0]                m_tdata,    // cursor_x, cursor_y, button_bits
    output logic [ps2mpc_pkg::STATUS_W-1:0]     m_tuser,    // byte_status
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ps2mpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ps2mpc_pkg::SIZE_W-1:0]       cfg_data
);
    import ps2mpc_pkg::*;

    localparam int EW = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
    localparam int VW = COORD_BITS + 2;
    localparam logic [EW-1:0] LIMIT = EW'(1) << COORD_BITS;

    function automatic logic [EW-1:0] eff_size(input logic [SIZE_W-1:0] setting,
                                               input logic [SIZE_W-1:0] fallback);
        logic [EW-1:0] s;
        s = (setting == '0) ? EW'(fallback) : EW'(setting);
        if (s > LIMIT) begin
            s = LIMIT;
        end
        return s;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp(input logic signed [VW-1:0] v,
                                                    input logic [EW-1:0] size);
        logic [VW-1:0] size_v;
        size_v = VW'(size);
        if (v < 0) begin
            return '0;
        end else if ($unsigned(v) >= size_v) begin
            return COORD_BITS'(size_v - VW'(1));
        end else begin
            return COORD_BITS'($unsigned(v));
        end
    endfunction

    logic                    in_valid_reg, in_valid_next;
    logic [DATA_W-1:0]       in_data_reg;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg;
    logic [COORD_BITS-1:0]   out_x_reg, out_y_reg;
    logic [BUTTON_W-1:0]     out_btn_reg;

    pos_t                    pos_reg, pos_next;
    logic [DATA_W-1:0]       flags_reg, flags_next;
    logic [DATA_W-1:0]       dx_reg, dx_next;
    logic [COORD_BITS-1:0]   x_reg, x_next, y_reg, y_next;
    logic [BUTTON_W-1:0]     btn_reg, btn_next;
    logic [SIZE_W-1:0]       width_reg, width_next, height_reg, height_next;

    logic                    advance, step, cfg_write;
    status_t                 status;
    logic [EW-1:0]           eff_w, eff_h, eff_w_new, eff_h_new;
    logic signed [8:0]       dx9, dy9;
    logic signed [VW-1:0]    sum_x, sum_y;

    assign advance   = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign eff_w = eff_size(width_reg, DEFAULT_WIDTH);
    assign eff_h = eff_size(height_reg, DEFAULT_HEIGHT);
    assign dx9   = $signed({flags_reg[SIGN_X_BIT], dx_reg});
    assign dy9   = $signed({flags_reg[SIGN_Y_BIT], in_data_reg});
    assign sum_x = $signed({2'b00, x_reg}) + VW'(dx9);
    assign sum_y = $signed({2'b00, y_reg}) - VW'(dy9);

    always_comb begin
        pos_next    = pos_reg;
        flags_next  = flags_reg;
        dx_next     = dx_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        btn_next    = btn_reg;
        width_next  = width_reg;
        height_next = height_reg;
        status      = STAT_STORED;
        eff_w_new   = eff_w;
        eff_h_new   = eff_h;

        if (step) begin
            case (pos_reg)
                POS_FLAGS: begin
                    if (!in_data_reg[SYNC_BIT]) begin
                        status = STAT_DROPPED;
                    end else begin
                        flags_next = in_data_reg;
                        pos_next   = POS_DX;
                    end
                end
                POS_DX: begin
                    dx_next  = in_data_reg;
                    pos_next = POS_DY;
                end
                default: begin
                    x_next   = clamp(sum_x, eff_w);
                    y_next   = clamp(sum_y, eff_h);
                    btn_next = flags_reg[BUTTON_W-1:0];
                    pos_next = POS_FLAGS;
                    status   = STAT_DONE;
                end
            endcase
        end

        if (cfg_write && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
            if (cfg_index == REG_WIDTH) begin
                width_next = cfg_data;
                eff_w_new  = eff_size(cfg_data, DEFAULT_WIDTH);
            end else begin
                height_next = cfg_data;
                eff_h_new   = eff_size(cfg_data, DEFAULT_HEIGHT);
            end
            x_next = COORD_BITS'(eff_w_new >> 1);
            y_next = COORD_BITS'(eff_h_new >> 1);
        end

        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_FLAGS;
            flags_reg     <= '0;
            dx_reg        <= '0;
            btn_reg       <= '0;
            width_reg     <= DEFAULT_WIDTH;
            height_reg    <= DEFAULT_HEIGHT;
            x_reg         <= COORD_BITS'(eff_size(DEFAULT_WIDTH, DEFAULT_WIDTH) >> 1);
            y_reg         <= COORD_BITS'(eff_size(DEFAULT_HEIGHT, DEFAULT_HEIGHT) >> 1);
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            flags_reg     <= flags_next;
            dx_reg        <= dx_next;
            btn_reg       <= btn_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (step) begin
            out_status_reg <= status;
            out_x_reg      <= x_next;
            out_y_reg      <= y_next;
            out_btn_reg    <= btn_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_TDATA_W'({out_btn_reg, out_y_reg, out_x_reg});

endmodule

### rtl/core/ps2mpc_checker.sv
module ps2mpc_checker #(
    parameter int COORD_BITS = 12,
    localparam int M_TDATA_W = ((2 * COORD_BITS + ps2mpc_pkg::BUTTON_W + 7) / 8) * 8
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [ps2mpc_pkg::DATA_W-1:0]       s_tdata,    // data_byte
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [M_TDATA_W-1:0]                m_tdata,    // cursor_x, cursor_y, button_bits
    input logic [ps2mpc_pkg::STATUS_W-1:0]     m_tuser,    // byte_status
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [ps2mpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input logic [ps2mpc_pkg::SIZE_W-1:0]       cfg_data
);
    import ps2mpc_pkg::*;

    logic                  out_word;
    logic [1:0]            run_cnt_reg;
    logic                  prev_valid_reg;
    logic                  cfg_seen_reg;
    logic [M_TDATA_W-1:0]  prev_data_reg;

    assign out_word = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_cnt_reg    <= '0;
            prev_valid_reg <= 1'b0;
            cfg_seen_reg   <= 1'b0;
        end else begin
            if (out_word) begin
                run_cnt_reg    <= (m_tuser == STAT_STORED) ? run_cnt_reg + 2'd1 : 2'd0;
                prev_valid_reg <= 1'b1;
                cfg_seen_reg   <= cfg_valid && cfg_ready;
            end else if (cfg_valid && cfg_ready) begin
                cfg_seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_word) begin
            prev_data_reg <= m_tdata;
        end
    end

    // Output framing: two stored words then a completed packet; drops only between packets.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_word |-> ((m_tuser == STAT_STORED && run_cnt_reg < 2'd2)
                   || (m_tuser == STAT_DROPPED && run_cnt_reg == 2'd0)
                   || (m_tuser == STAT_DONE && run_cnt_reg == 2'd2)))
        else $error("byte_status out of packet order");

    // Only a completed packet or a size write may move the cursor or the buttons.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_word && m_tuser != STAT_DONE && prev_valid_reg && !cfg_seen_reg)
            |-> m_tdata == prev_data_reg)
        else $error("cursor changed without a completed packet");

    // The input side stalls only behind a waiting result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind ps2_mouse_packet_cursor ps2mpc_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

### dv/ps2_mouse_packet_cursor_checker.sv
`timescale 1ns / 100ps

module ps2_mouse_packet_cursor_checker #(
    parameter int COORD_BITS = 12,
    localparam int M_TDATA_W = ((2 * COORD_BITS + ps2mpc_pkg::BUTTON_W + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ps2mpc_pkg::DATA_W-1:0]       s_tdata,    // data_byte
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [M_TDATA_W-1:0]                m_tdata,    // cursor_x, cursor_y, button_bits
    input  logic [ps2mpc_pkg::STATUS_W-1:0]     m_tuser,    // byte_status
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ps2mpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ps2mpc_pkg::SIZE_W-1:0]       cfg_data,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  bytes_taken,
    output int                                  packets_done,
    output int                                  bytes_dropped
);
    import ps2mpc_pkg::*;

    typedef struct packed {
        status_t               status;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [BUTTON_W-1:0]   buttons;
    } cursor_word_t;

    cursor_word_t          cursor_words_due [$];
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    pos_t                  byte_slot;
    logic [DATA_W-1:0]     flags_q;
    logic [DATA_W-1:0]     dx_q;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic [BUTTON_W-1:0]   buttons_q;

    initial begin
        mismatches    = 0;
        outstanding   = 0;
        bytes_taken   = 0;
        packets_done  = 0;
        bytes_dropped = 0;
    end

    function automatic int screen_extent(logic [SIZE_W-1:0] setting, logic [SIZE_W-1:0] fallback);
        int s;
        s = (setting == '0) ? int'(fallback) : int'(setting);
        if (s > (1 << COORD_BITS)) s = 1 << COORD_BITS;
        return s;
    endfunction

    function automatic int clamp_to_screen(int v, int extent);
        if (v < 0) return 0;
        if (v >= extent) return extent - 1;
        return v;
    endfunction

    function automatic int signed_delta(logic [DATA_W-1:0] low, logic negative);
        return negative ? int'(low) - 256 : int'(low);
    endfunction

    task automatic recenter_cursor();
        cur_x = COORD_BITS'(screen_extent(width_reg, DEFAULT_WIDTH) / 2);
        cur_y = COORD_BITS'(screen_extent(height_reg, DEFAULT_HEIGHT) / 2);
    endtask

    task automatic decode_mouse_byte(input logic [DATA_W-1:0] b);
        cursor_word_t word;
        int           dx;
        int           dy;
        word.status = STAT_STORED;
        case (byte_slot)
            POS_FLAGS: begin
                if (!b[SYNC_BIT]) begin
                    word.status = STAT_DROPPED;
                    bytes_dropped++;
                end else begin
                    flags_q   = b;
                    byte_slot = POS_DX;
                end
            end
            POS_DX: begin
                dx_q      = b;
                byte_slot = POS_DY;
            end
            default: begin
                dx        = signed_delta(dx_q, flags_q[SIGN_X_BIT]);
                dy        = signed_delta(b, flags_q[SIGN_Y_BIT]);
                cur_x     = COORD_BITS'(clamp_to_screen(int'(cur_x) + dx,
                                screen_extent(width_reg, DEFAULT_WIDTH)));
                cur_y     = COORD_BITS'(clamp_to_screen(int'(cur_y) - dy,
                                screen_extent(height_reg, DEFAULT_HEIGHT)));
                buttons_q = flags_q[BUTTON_W-1:0];
                byte_slot = POS_FLAGS;
                word.status = STAT_DONE;
                packets_done++;
            end
        endcase
        word.x       = cur_x;
        word.y       = cur_y;
        word.buttons = buttons_q;
        cursor_words_due.push_back(word);
        bytes_taken++;
    endtask

    task automatic compare_cursor_word();
        cursor_word_t          want;
        logic [COORD_BITS-1:0] got_x;
        logic [COORD_BITS-1:0] got_y;
        logic [BUTTON_W-1:0]   got_buttons;
        got_x       = m_tdata[COORD_BITS-1:0];
        got_y       = m_tdata[COORD_BITS +: COORD_BITS];
        got_buttons = m_tdata[2*COORD_BITS +: BUTTON_W];
        if (cursor_words_due.size() == 0) begin
            $display("%0t: unexpected word: status %0d x %0d y %0d buttons %0d",
                     $time, m_tuser, got_x, got_y, got_buttons);
            mismatches++;
        end else begin
            want = cursor_words_due.pop_front();
            if (m_tuser !== want.status) begin
                $display("%0t: byte_status expected %0d actual %0d", $time, want.status, m_tuser);
                mismatches++;
            end
            if (got_x !== want.x) begin
                $display("%0t: cursor_x expected %0d actual %0d", $time, want.x, got_x);
                mismatches++;
            end
            if (got_y !== want.y) begin
                $display("%0t: cursor_y expected %0d actual %0d", $time, want.y, got_y);
                mismatches++;
            end
            if (got_buttons !== want.buttons) begin
                $display("%0t: button_bits expected %0d actual %0d",
                         $time, want.buttons, got_buttons);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = DEFAULT_WIDTH;
            height_reg = DEFAULT_HEIGHT;
            byte_slot  = POS_FLAGS;
            flags_q    = '0;
            dx_q       = '0;
            buttons_q  = '0;
            recenter_cursor();
            cursor_words_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_WIDTH) begin
                    width_reg = cfg_data;
                    recenter_cursor();
                end else if (cfg_index == REG_HEIGHT) begin
                    height_reg = cfg_data;
                    recenter_cursor();
                end
            end
            if (s_tvalid && s_tready) decode_mouse_byte(s_tdata);
            if (m_tvalid && m_tready) compare_cursor_word();
        end
        outstanding = cursor_words_due.size();
    end

endmodule

### dv/ps2_mouse_packet_cursor_tb.sv
`timescale 1ns / 100ps

module ps2_mouse_packet_cursor_tb;
    import ps2mpc_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int M_TDATA_W       = ((2 * COORD_BITS + BUTTON_W + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int PHASES          = 12;
    localparam int PHASE_BYTES     = 48;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]      cfg_data  = '0;

    int mismatches;
    int outstanding;
    int bytes_taken;
    int packets_done;
    int bytes_dropped;
    int quiet_cycles = 0;
    int size_settings = 0;
    int rx_stall;
    bit steady_flow  = 1'b0;
    bit hold_off_req = 1'b0;

    always #2 aclk = ~aclk;

    ps2_mouse_packet_cursor #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ps2_mouse_packet_cursor_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .bytes_taken   (bytes_taken),
        .packets_done  (packets_done),
        .bytes_dropped (bytes_dropped)
    );

    function automatic int pause_len();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // The receiver stalls at random, or for a long stretch when the stimulus asks.
    always begin
        @(posedge aclk);
        if (hold_off_req) begin
            m_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            hold_off_req = 1'b0;
        end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            rx_stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(6, 30);
            repeat (rx_stall) @(posedge aclk);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d results still due",
                         $time, WATCHDOG_LIMIT, outstanding);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [DATA_W-1:0] b);
        int gap;
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = pause_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_delta();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_traffic(input int n_bytes);
        int                count;
        int                kind;
        logic [DATA_W-1:0] flags;
        logic [DATA_W-1:0] b;
        count = 0;
        while (count < n_bytes) begin
            kind  = $urandom_range(0, 99);
            flags = DATA_W'($urandom);
            flags[SYNC_BIT] = 1'b1;
            if (kind < 84) begin
                send_byte(flags);
                send_byte(pick_delta());
                send_byte(pick_delta());
                count += 3;
            end else if (kind < 88) begin
                // Truncated packet: the next packet lands out of step.
                send_byte(flags);
                send_byte(pick_delta());
                count += 2;
            end else begin
                b = DATA_W'($urandom);
                if ($urandom_range(0, 3) != 0) b[SYNC_BIT] = 1'b0;
                send_byte(b);
                if (b[SYNC_BIT]) count++;
            end
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    initial begin
        logic [DATA_W-1:0] opening_bytes [0:25];
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        // Out-of-sync drops, zero move, full positive and negative deltas, overflow
        // flags, repeated pushes against the left edge, and a packet whose Y byte
        // has its sync bit clear.
        opening_bytes = '{8'h00, 8'hF7, 8'h08, 8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF,
                          8'h38, 8'h00, 8'h00, 8'hC9, 8'h7F, 8'h80, 8'h18, 8'h00,
                          8'h00, 8'h18, 8'h00, 8'h00, 8'h18, 8'h01, 8'h00, 8'h2A,
                          8'h55, 8'h00};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 26; i++) send_byte(opening_bytes[i]);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    w = '0;
                    h = '0;
                end
                1: begin
                    w = 13'd1;
                    h = 13'd1;
                end
                2: begin
                    w = 13'd4096;
                    h = 13'd4096;
                end
                3: begin
                    w = 13'd2;
                    h = 13'd4096;
                end
                4: begin
                    w = 13'd4096;
                    h = 13'd1;
                end
                default: begin
                    w = ($urandom_range(0, 1) == 0) ? SIZE_W'($urandom_range(0, 4096))
                                                    : SIZE_W'($urandom_range(1, 40));
                    h = ($urandom_range(0, 1) == 0) ? SIZE_W'($urandom_range(0, 4096))
                                                    : SIZE_W'($urandom_range(1, 40));
                end
            endcase
            drain_results();
            cfg_write(REG_WIDTH, w);
            cfg_write(REG_HEIGHT, h);
            if (phase == 5) cfg_write(REG_SPARE, SIZE_W'($urandom));
            cfg_valid <= 1'b0;
            size_settings++;
            steady_flow = (phase % 4 == 3);

            if (phase == 6) begin
                hold_off_req = 1'b1;
                steady_flow  = 1'b1;
                send_traffic(24);
                steady_flow  = 1'b0;
            end
            send_traffic(PHASE_BYTES);
        end

        drain_results();
        repeat (8) @(posedge aclk);
        $display("Sent %0d bytes across %0d screen-size settings, with one long output stall.",
                 bytes_taken, size_settings);
        $display("Decoded %0d packets and saw %0d out-of-sync bytes dropped.",
                 packets_done, bytes_dropped);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
